// ===== rtl/core/ict_pkg.sv =====
// Package for the INI byte tokenizer: string capacities, character codes,
// token roles, parser state type and the structs passed between modules.
// No dependencies; every other file imports it.
`default_nettype none

package ict_pkg;

	// String capacities; a string of capacity CAP keeps CAP-1 characters.
	localparam int SECTION_CAP = 64;
	localparam int KEY_CAP     = 64;
	localparam int VALUE_CAP   = 256;

	localparam int SEC_LEN_W = $clog2(SECTION_CAP);
	localparam int KEY_LEN_W = $clog2(KEY_CAP);
	localparam int VAL_LEN_W = $clog2(VALUE_CAP);

	localparam logic [SEC_LEN_W-1:0] SEC_LIMIT = SEC_LEN_W'(SECTION_CAP - 1);
	localparam logic [KEY_LEN_W-1:0] KEY_LIMIT = KEY_LEN_W'(KEY_CAP - 1);
	localparam logic [VAL_LEN_W-1:0] VAL_LIMIT = VAL_LEN_W'(VALUE_CAP - 1);

	localparam logic [7:0] CH_NUL      = 8'h00;
	localparam logic [7:0] CH_LBRACKET = 8'h5B;
	localparam logic [7:0] CH_RBRACKET = 8'h5D;
	localparam logic [7:0] CH_EQUALS   = 8'h3D;
	localparam logic [7:0] CH_HASH     = 8'h23;
	localparam logic [7:0] CH_NEWLINE  = 8'h0A;
	localparam logic [7:0] CH_SPACE    = 8'h20;
	localparam logic [7:0] CH_TAB      = 8'h09;
	localparam logic [7:0] CH_CR       = 8'h0D;

	typedef enum logic [2:0] {
		ROLE_IGNORED   = 3'd0,
		ROLE_SEC_OPEN  = 3'd1,
		ROLE_SEC_CHAR  = 3'd2,
		ROLE_KEY_CHAR  = 3'd3,
		ROLE_VAL_CHAR  = 3'd4,
		ROLE_PAIR_DONE = 3'd5,
		ROLE_ERROR     = 3'd6
	} role_t;

	typedef enum logic [8:0] {
		ST_LINE     = 9'b000000001,
		ST_SEC_OPEN = 9'b000000010,
		ST_SEC_NAME = 9'b000000100,
		ST_SEC_DONE = 9'b000001000,
		ST_KEY      = 9'b000010000,
		ST_KEY_DONE = 9'b000100000,
		ST_EQ       = 9'b001000000,
		ST_VALUE    = 9'b010000000,
		ST_COMMENT  = 9'b100000000
	} parse_state_t;

	typedef struct packed {
		parse_state_t           st;
		logic [SEC_LEN_W-1:0]   sec_len;
		logic [KEY_LEN_W-1:0]   key_len;
		logic [VAL_LEN_W-1:0]   val_len;
		logic                   stopped;
	} pstate_t;

	typedef struct packed {
		role_t      role;
		logic [7:0] char_out;
		logic [7:0] position;
		logic       dropped;
		logic       finished;
	} token_t;

endpackage

`default_nettype wire

// ===== rtl/core/ict_text_if.sv =====
// Input channel of the INI byte tokenizer: one text byte and an end flag.
// Imports ict_pkg; carries the valid/ready handshake it defines.
`default_nettype none

interface ict_text_if import ict_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_file;

	modport source (output valid, output data_byte, output end_of_file, input ready);
	modport sink   (input valid, input data_byte, input end_of_file, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ict_token_if.sv =====
// Output channel of the INI byte tokenizer: one tagged character per item.
// Depends on ict_pkg for the role type.
`default_nettype none

interface ict_token_if import ict_pkg::*; ();
	logic       valid;
	logic       ready;
	role_t      role;
	logic [7:0] char_out;
	logic [7:0] position;
	logic       dropped;
	logic       finished;

	modport source (output valid, output role, output char_out, output position,
		output dropped, output finished, input ready);
	modport sink   (input valid, input role, input char_out, input position,
		input dropped, input finished, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ict_step.sv =====
// Combinational parser step: next parser state and the token for one byte.
// Depends on ict_pkg for the state, token and constant definitions.
`default_nettype none

module ict_step import ict_pkg::*; (
	input  pstate_t    cur,
	input  logic [7:0] data_byte,
	input  logic       end_of_file,
	output pstate_t    nxt,
	output token_t     tok
);

	logic                 blank;
	logic                 sec_full, key_full, val_full;
	logic [7:0]           sec_pos, key_pos, val_pos;
	logic [SEC_LEN_W-1:0] sec_next;
	logic [KEY_LEN_W-1:0] key_next;
	logic [VAL_LEN_W-1:0] val_next;

	// C-locale whitespace: tab through carriage return, and space.
	assign blank = (data_byte == CH_SPACE) || ((data_byte >= CH_TAB) && (data_byte <= CH_CR));

	// A full string keeps its length and reports the last slot as dropped.
	assign sec_full = (cur.sec_len == SEC_LIMIT);
	assign key_full = (cur.key_len == KEY_LIMIT);
	assign val_full = (cur.val_len == VAL_LIMIT);
	assign sec_pos  = 8'(cur.sec_len);
	assign key_pos  = 8'(cur.key_len);
	assign val_pos  = 8'(cur.val_len);
	assign sec_next = sec_full ? cur.sec_len : cur.sec_len + SEC_LEN_W'(1);
	assign key_next = key_full ? cur.key_len : cur.key_len + KEY_LEN_W'(1);
	assign val_next = val_full ? cur.val_len : cur.val_len + VAL_LEN_W'(1);

	always_comb begin
		nxt          = cur;
		tok.role     = ROLE_IGNORED;
		tok.char_out = end_of_file ? 8'd0 : data_byte;
		tok.position = 8'd0;
		tok.dropped  = 1'b0;
		tok.finished = 1'b0;

		if (cur.stopped) begin
			tok.finished = 1'b1;
		end else if (end_of_file) begin
			if (cur.st == ST_VALUE) begin
				tok.role    = ROLE_PAIR_DONE;
				nxt.key_len = '0;
				nxt.val_len = '0;
			end else if (cur.st != ST_LINE && cur.st != ST_COMMENT) begin
				tok.role = ROLE_ERROR;
			end
			nxt.stopped  = 1'b1;
			tok.finished = 1'b1;
		end else if (data_byte == CH_NUL) begin
			nxt.stopped  = 1'b1;
			tok.finished = 1'b1;
		end else begin
			unique case (cur.st)
				ST_SEC_OPEN, ST_SEC_NAME: begin
					if (data_byte == CH_RBRACKET) begin
						nxt.st = ST_LINE;
					end else if (blank) begin
						if (cur.st == ST_SEC_NAME) nxt.st = ST_SEC_DONE;
					end else begin
						tok.role     = ROLE_SEC_CHAR;
						tok.position = sec_pos;
						tok.dropped  = sec_full;
						nxt.sec_len  = sec_next;
						nxt.st       = ST_SEC_NAME;
					end
				end
				ST_SEC_DONE: begin
					if (data_byte == CH_RBRACKET) nxt.st = ST_LINE;
					else if (!blank) tok.role = ROLE_ERROR;
				end
				ST_KEY, ST_KEY_DONE: begin
					if (data_byte == CH_EQUALS) begin
						nxt.st = ST_EQ;
					end else if (blank) begin
						nxt.st = ST_KEY_DONE;
					end else if (cur.st == ST_KEY) begin
						tok.role     = ROLE_KEY_CHAR;
						tok.position = key_pos;
						tok.dropped  = key_full;
						nxt.key_len  = key_next;
					end else begin
						tok.role = ROLE_ERROR;
					end
				end
				ST_EQ: begin
					if (!blank) begin
						tok.role     = ROLE_VAL_CHAR;
						tok.position = val_pos;
						tok.dropped  = val_full;
						nxt.val_len  = val_next;
						nxt.st       = ST_VALUE;
					end
				end
				ST_VALUE: begin
					if (data_byte == CH_HASH || data_byte == CH_NEWLINE) begin
						tok.role    = ROLE_PAIR_DONE;
						nxt.key_len = '0;
						nxt.val_len = '0;
						nxt.st      = (data_byte == CH_HASH) ? ST_COMMENT : ST_LINE;
					end else begin
						tok.role     = ROLE_VAL_CHAR;
						tok.position = val_pos;
						tok.dropped  = val_full;
						nxt.val_len  = val_next;
					end
				end
				ST_COMMENT: begin
					if (data_byte == CH_NEWLINE) nxt.st = ST_LINE;
				end
				default: begin
					// Line start.
					if (data_byte == CH_LBRACKET) begin
						tok.role    = ROLE_SEC_OPEN;
						nxt.sec_len = '0;
						nxt.st      = ST_SEC_OPEN;
					end else if (data_byte == CH_EQUALS) begin
						tok.role = ROLE_ERROR;
					end else if (blank) begin
						nxt.st = ST_LINE;
					end else if (data_byte == CH_HASH) begin
						nxt.st = ST_COMMENT;
					end else begin
						tok.role     = ROLE_KEY_CHAR;
						tok.position = key_pos;
						tok.dropped  = key_full;
						nxt.key_len  = key_next;
						nxt.st       = ST_KEY;
					end
				end
			endcase
			if (tok.role == ROLE_ERROR) begin
				nxt.stopped  = 1'b1;
				tok.finished = 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/ini_config_byte_tokenizer_unit.sv =====
// The tokenizer takes one text byte per item and returns exactly one token item for it,
// and it sustains one item per clock cycle while token.ready does not stall it. A byte is
// latched in an input register, the parser step and the length counters resolve it
// combinationally, and the token sits in an output register, so a token is offered once
// its byte has passed the input register and then the output register. The single parser
// state register sets that rate: each byte sees the state left by the byte before.
// text.ready depends combinationally on token.ready. After the end flag, a zero byte or an
// error, every further item is answered with an ignored token marked finished until reset.
`default_nettype none

module ini_config_byte_tokenizer_unit import ict_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	ict_text_if.sink   text,
	ict_token_if.source token
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eof_s1;
	pstate_t    state_q;
	pstate_t    state_nxt;
	token_t     tok_nxt;
	token_t     tok_q;
	logic       out_valid_q;
	logic       out_free;
	logic       advance;

	ict_step u_step (
		.cur         (state_q),
		.data_byte   (byte_s1),
		.end_of_file (eof_s1),
		.nxt         (state_nxt),
		.tok         (tok_nxt)
	);

	assign out_free   = !out_valid_q || token.ready;
	assign advance    = valid_s1 && out_free;
	assign text.ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.ready) begin
			valid_s1 <= text.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text.ready && text.valid) begin
			byte_s1 <= text.data_byte;
			eof_s1  <= text.end_of_file;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.st      <= ST_LINE;
			state_q.sec_len <= '0;
			state_q.key_len <= '0;
			state_q.val_len <= '0;
			state_q.stopped <= 1'b0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			tok_q <= tok_nxt;
		end
	end

	assign token.valid    = out_valid_q;
	assign token.role     = tok_q.role;
	assign token.char_out = tok_q.char_out;
	assign token.position = tok_q.position;
	assign token.dropped  = tok_q.dropped;
	assign token.finished = tok_q.finished;

endmodule

`default_nettype wire
